// ===== sv/hsvp_pkg.sv =====
package hsvp_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned FIELD_W   = 18;
  localparam int unsigned UNIT_W    = FRAC_BITS + 1;
  localparam int unsigned PROD_W    = 2 * UNIT_W;
  localparam int unsigned COLOR_W   = 32;
  localparam logic [7:0]  ALPHA     = 8'hff;

  typedef logic signed [FIELD_W-1:0] field_t;
  typedef logic [UNIT_W-1:0]         unit_t;
  typedef logic [FRAC_BITS-1:0]      frac_t;
  typedef logic [COLOR_W-1:0]        color_t;

  localparam unit_t ONE = unit_t'(1) << FRAC_BITS;

  // Hue sectors, named by the pair of primaries and secondaries they span.
  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_e;

  // Load enables of the three register stages, first stage in bit 0.
  typedef struct packed {
    logic [2:0] load;
  } pipe_ctrl_t;

  function automatic unit_t clamp_unit(field_t x);
    unit_t res;
    if (x[FIELD_W-1]) begin
      res = '0;
    end else if (x > $signed({1'b0, FIELD_W'(ONE)})) begin
      res = ONE;
    end else begin
      res = x[UNIT_W-1:0];
    end
    return res;
  endfunction

  // Product of two values in [0, ONE], truncated back to the unit format.
  function automatic unit_t mul_unit(unit_t a, unit_t b);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(a) * PROD_W'(b);
    return prod[FRAC_BITS+UNIT_W-1:FRAC_BITS];
  endfunction

  // Scales a value in [0, ONE] to a byte as x * 255 >> FRAC_BITS.
  function automatic logic [7:0] to_byte(unit_t x);
    logic [UNIT_W+7:0] prod;
    prod = {x, 8'b0} - (UNIT_W + 8)'(x);
    return prod[FRAC_BITS+7:FRAC_BITS];
  endfunction

endpackage

// ===== sv/hsvp_in_if.sv =====
interface hsvp_in_if;
  logic                 valid;
  logic                 ready;
  logic                 mode;
  hsvp_pkg::field_t     hue_or_red;
  hsvp_pkg::field_t     sat_or_green;
  hsvp_pkg::field_t     val_or_blue;

  modport source (output valid, mode, hue_or_red, sat_or_green, val_or_blue, input ready);
  modport sink   (input valid, mode, hue_or_red, sat_or_green, val_or_blue, output ready);
endinterface

// ===== sv/hsvp_out_if.sv =====
interface hsvp_out_if;
  logic             valid;
  logic             ready;
  hsvp_pkg::color_t packed_color;

  modport source (output valid, packed_color, input ready);
  modport sink   (input valid, packed_color, output ready);
endinterface

// ===== sv/hsv_to_rgba_packer.sv =====
// Channel  Dir  Payload
// in_i     in   mode, hue_or_red, sat_or_green, val_or_blue
// out_o    out  packed_color (red 31:24, green 23:16, blue 15:8, alpha 7:0)
//
// One item per cycle sustained while the output is ready; an item passes three register
// stages (hue split, fraction products, value products) and leaves from the last of
// them, the output register.
// The depth is set by the two dependent multiplier ranks of the hue path.
// Reset clears only the valid bits of the three stages.
// A stall at the output holds each stage that is full and lets empty stages
// behind it fill, so no item is lost or repeated.
module hsv_to_rgba_packer (
  input  logic       clk_i,
  input  logic       rst_ni,
  hsvp_in_if.sink    in_i,
  hsvp_out_if.source out_o
);
  import hsvp_pkg::*;

  pipe_ctrl_t ctrl;

  hsvp_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .ctrl_o      (ctrl)
  );

  // Stage one: clamp, hue fraction times six, sector split.
  logic [FRAC_BITS+2:0] h6;
  frac_t                hue_frac;
  unit_t                sat_c, val_c, red_c;
  sector_e              s1_sector_q;
  frac_t                s1_f_q;
  unit_t                s1_s_q, s1_v_q, s1_r_q;
  logic                 s1_mode_q;

  always_comb begin
    hue_frac = in_i.hue_or_red[FRAC_BITS-1:0];
    h6       = {1'b0, hue_frac, 2'b0} + {2'b0, hue_frac, 1'b0};
    sat_c    = clamp_unit(in_i.sat_or_green);
    val_c    = clamp_unit(in_i.val_or_blue);
    red_c    = clamp_unit(in_i.hue_or_red);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load[0]) begin
      s1_mode_q   <= in_i.mode;
      s1_sector_q <= sector_e'(h6[FRAC_BITS+2:FRAC_BITS]);
      s1_f_q      <= h6[FRAC_BITS-1:0];
      s1_s_q      <= sat_c;
      s1_v_q      <= val_c;
      s1_r_q      <= red_c;
    end
  end

  // Stage two: saturation times fraction and times its complement.
  unit_t   sf, sfn;
  unit_t   s2_oms_q, s2_qa_q, s2_tb_q, s2_s_q, s2_v_q, s2_r_q;
  sector_e s2_sector_q;
  logic    s2_mode_q;

  always_comb begin
    sf  = mul_unit(s1_s_q, {1'b0, s1_f_q});
    sfn = mul_unit(s1_s_q, ONE - {1'b0, s1_f_q});
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load[1]) begin
      s2_mode_q   <= s1_mode_q;
      s2_sector_q <= s1_sector_q;
      s2_oms_q    <= ONE - s1_s_q;
      s2_qa_q     <= ONE - sf;
      s2_tb_q     <= ONE - sfn;
      s2_s_q      <= s1_s_q;
      s2_v_q      <= s1_v_q;
      s2_r_q      <= s1_r_q;
    end
  end

  // Output stage: p, q, t, routing by sector (or direct RGB when mode is set) and byte packing.
  unit_t      p, q, t, red, grn, blu;
  color_t     packed_q;

  always_comb begin
    p = mul_unit(s2_v_q, s2_oms_q);
    q = mul_unit(s2_v_q, s2_qa_q);
    t = mul_unit(s2_v_q, s2_tb_q);
    if (s2_mode_q) begin
      red = s2_r_q;
      grn = s2_s_q;
      blu = s2_v_q;
    end else begin
      case (s2_sector_q)
        SEC_RY:  begin red = s2_v_q; grn = t;      blu = p;      end
        SEC_YG:  begin red = q;      grn = s2_v_q; blu = p;      end
        SEC_GC:  begin red = p;      grn = s2_v_q; blu = t;      end
        SEC_CB:  begin red = p;      grn = q;      blu = s2_v_q; end
        SEC_BM:  begin red = t;      grn = p;      blu = s2_v_q; end
        default: begin red = s2_v_q; grn = p;      blu = q;      end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load[2]) begin
      packed_q <= {to_byte(red), to_byte(grn), to_byte(blu), ALPHA};
    end
  end

  assign out_o.packed_color = packed_q;

endmodule

// ===== sv/hsvp_pipe_ctrl.sv =====
module hsvp_pipe_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output hsvp_pkg::pipe_ctrl_t ctrl_o
);
  import hsvp_pkg::*;

  logic [2:0] valid_q, valid_d;
  logic [2:0] load;

  // A stage takes new data when it is empty or its content moves on.
  always_comb begin
    load[2] = !valid_q[2] || out_ready_i;
    load[1] = !valid_q[1] || load[2];
    load[0] = !valid_q[0] || load[1];
    valid_d = valid_q;
    if (load[0]) begin
      valid_d[0] = in_valid_i;
    end
    if (load[1]) begin
      valid_d[1] = valid_q[0];
    end
    if (load[2]) begin
      valid_d[2] = valid_q[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = load[0];
  assign out_valid_o = valid_q[2];
  assign ctrl_o.load = load;

`ifndef SYNTHESIS
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> valid_q[0])
    else $error("accepted item did not enter the first stage");

  a_stall_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[1] && valid_q[2] && !out_ready_i |=> valid_q[1] && valid_q[2])
    else $error("item dropped while the output stalls");

  a_empty_out_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q[2] |-> in_ready_o)
    else $error("pipeline refuses input with an empty output stage");

  a_out_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[1] && !valid_q[2] |=> valid_q[2])
    else $error("item did not advance into an empty output stage");
`endif

endmodule
